[rtl/divider_timer_with_modulo_reload_top_defines.svh]
// Assertion macros shared by the divider timer RTL.
`ifndef DIVIDER_TIMER_WITH_MODULO_RELOAD_TOP_DEFINES_SVH
`define DIVIDER_TIMER_WITH_MODULO_RELOAD_TOP_DEFINES_SVH

// Checked outside reset.
`define DTMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define DTMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/dtmr_pkg.sv]
// Types, constants and helpers shared by the divider timer modules.
package dtmr_pkg;

  // Bus operation codes on the input channel
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Register addresses
  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA = 16'hFF05;
  localparam logic [15:0] ADDR_TMA  = 16'hFF06;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;

  localparam int DIV_WIDTH   = 16;
  localparam int BYTE_WIDTH  = 8;
  localparam int CTRL_WIDTH  = 3;
  localparam int CYC_WIDTH   = 3;
  localparam int CTRL_EN_BIT = 2;

  // Unused TAC bits read back as ones
  localparam logic [BYTE_WIDTH-CTRL_WIDTH-1:0] TAC_READ_FILL = '1;

  // Command queue between decode and execute
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // Decoded command kinds
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_RD_DIV,
    CMD_RD_TIMA,
    CMD_RD_TAC,
    CMD_WR_DIV,
    CMD_WR_TIMA,
    CMD_WR_TMA,
    CMD_WR_TAC
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [BYTE_WIDTH-1:0]   data;
    logic [CYC_WIDTH-1:0]    cycles;
  } cmd_t;

  // Queue read side handshake toward the execute stage
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  // Divider tap for each clock select: 9, 3, 5, 7
  function automatic logic [3:0] tap_index(input logic [1:0] sel);
    logic [3:0] idx;
    case (sel)
      2'd0:    idx = 4'd9;
      2'd1:    idx = 4'd3;
      2'd2:    idx = 4'd5;
      2'd3:    idx = 4'd7;
      default: idx = 4'd9;
    endcase
    return idx;
  endfunction

endpackage

[rtl/dtmr_front.sv]
// Front end: decodes each input beat into a timer command.
module dtmr_front
  import dtmr_pkg::*;
(
  input  logic [1:0]            operation,
  input  logic [15:0]           address,
  input  logic [BYTE_WIDTH-1:0] write_data,
  input  logic [CYC_WIDTH-1:0]  elapsed_cycles,
  output cmd_t                  cmd
);

  op_t op;
  assign op = op_t'(operation);

  // Classify by operation and register address
  always_comb begin
    cmd.kind   = CMD_NOP;
    cmd.data   = write_data;
    cmd.cycles = elapsed_cycles;
    case (op)
      OP_TICK: begin
        cmd.kind = CMD_TICK;
      end
      OP_READ: begin
        if (address == ADDR_DIV)       cmd.kind = CMD_RD_DIV;
        else if (address == ADDR_TIMA) cmd.kind = CMD_RD_TIMA;
        else if (address == ADDR_TAC)  cmd.kind = CMD_RD_TAC;
      end
      OP_WRITE: begin
        if (address == ADDR_DIV)       cmd.kind = CMD_WR_DIV;
        else if (address == ADDR_TIMA) cmd.kind = CMD_WR_TIMA;
        else if (address == ADDR_TMA)  cmd.kind = CMD_WR_TMA;
        else if (address == ADDR_TAC)  cmd.kind = CMD_WR_TAC;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

[rtl/dtmr_queue.sv]
// Small command FIFO between the decode front and the execute back.
module dtmr_queue
  import dtmr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   push_cmd,
  output logic   full,
  input  logic   pop,
  output qhead_t head
);

`include "divider_timer_with_modulo_reload_top_defines.svh"

  cmd_t                  slots [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full       = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  // Pointer wrap helper
  function automatic logic [QPTR_WIDTH-1:0] bump(input logic [QPTR_WIDTH-1:0] p);
    logic [QPTR_WIDTH-1:0] r;
    if (p == QPTR_WIDTH'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + QPTR_WIDTH'(1);
    return r;
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop)      count <= count + QCNT_WIDTH'(1);
      else if (do_pop && !do_push) count <= count - QCNT_WIDTH'(1);
    end
  end

  `DTMR_ASSERT(a_count_bound, count <= QCNT_WIDTH'(QUEUE_DEPTH), "queue count over depth")
  `DTMR_ASSERT(a_ptr_gap, (count == '0 || full) |-> (wr_ptr == rd_ptr), "queue pointers out of step")
  `DTMR_ASSERT(a_pop_has_data, pop |-> head.valid, "pop from an empty queue")

endmodule

[rtl/dtmr_back.sv]
// Execute back end: timer state, command execution and output register.
module dtmr_back
  import dtmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  qhead_t                head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_WIDTH-1:0] read_data,
  output logic                  handled,
  output logic                  timer_interrupt
);

`include "divider_timer_with_modulo_reload_top_defines.svh"

  logic [DIV_WIDTH-1:0]  divider_count, divider_count_next;
  logic [BYTE_WIDTH-1:0] timer_count, timer_count_next;
  logic [BYTE_WIDTH-1:0] modulo_value, modulo_value_next;
  logic [CTRL_WIDTH-1:0] control_bits, control_bits_next;
  logic [BYTE_WIDTH-1:0] rd_next;
  logic                  hit_next;
  logic                  irq_next;
  logic [DIV_WIDTH-1:0]  div_sum;
  logic [3:0]            tap;

  // Take a command when the output slot is free or draining
  assign pop = head.valid && (!out_valid || !out_stall);

  assign tap     = tap_index(control_bits[1:0]);
  assign div_sum = divider_count + {{(DIV_WIDTH-CYC_WIDTH){1'b0}}, head.cmd.cycles};

  // Execute one command
  always_comb begin
    divider_count_next = divider_count;
    timer_count_next   = timer_count;
    modulo_value_next  = modulo_value;
    control_bits_next  = control_bits;
    rd_next            = '0;
    hit_next           = 1'b0;
    irq_next           = 1'b0;
    case (head.cmd.kind)
      CMD_TICK: begin
        divider_count_next = div_sum;
        // step on a falling edge of the selected divider bit
        if (control_bits[CTRL_EN_BIT] && divider_count[tap] && !div_sum[tap]) begin
          if (timer_count == '1) begin
            timer_count_next = modulo_value;
            irq_next         = 1'b1;
          end else begin
            timer_count_next = timer_count + BYTE_WIDTH'(1);
          end
        end
      end
      CMD_RD_DIV: begin
        rd_next  = divider_count[DIV_WIDTH-1 -: BYTE_WIDTH];
        hit_next = 1'b1;
      end
      CMD_RD_TIMA: begin
        rd_next  = timer_count;
        hit_next = 1'b1;
      end
      CMD_RD_TAC: begin
        rd_next  = {TAC_READ_FILL, control_bits};
        hit_next = 1'b1;
      end
      CMD_WR_DIV: begin
        divider_count_next = '0;
        hit_next           = 1'b1;
      end
      CMD_WR_TIMA: begin
        timer_count_next = head.cmd.data;
        hit_next         = 1'b1;
      end
      CMD_WR_TMA: begin
        modulo_value_next = head.cmd.data;
        hit_next          = 1'b1;
      end
      CMD_WR_TAC: begin
        control_bits_next = head.cmd.data[CTRL_WIDTH-1:0];
        // enable rising loads the counter from the modulo value
        if (!control_bits[CTRL_EN_BIT] && head.cmd.data[CTRL_EN_BIT])
          timer_count_next = modulo_value;
        hit_next = 1'b1;
      end
      default: begin
        hit_next = 1'b0;
      end
    endcase
  end

  // Timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_count <= '0;
      timer_count   <= '0;
      modulo_value  <= '0;
      control_bits  <= '0;
    end else if (pop) begin
      divider_count <= divider_count_next;
      timer_count   <= timer_count_next;
      modulo_value  <= modulo_value_next;
      control_bits  <= control_bits_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      read_data       <= rd_next;
      handled         <= hit_next;
      timer_interrupt <= irq_next;
    end
  end

  `DTMR_ASSERT(a_irq_not_access, out_valid && timer_interrupt |-> !handled, "interrupt on a bus access")
  `DTMR_ASSERT(a_data_needs_hit, out_valid && (read_data != '0) |-> handled, "read data without a hit")
  `DTMR_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> (divider_count == '0 && control_bits == '0), "state not cleared by reset")

endmodule

[rtl/divider_timer_with_modulo_reload_top.sv]
// An accepted beat is written to the command queue, then executed into the output register.
// Throughput: one beat per cycle without out_stall; a two-entry queue links decode and execute.
// The output register holds a finished result under stall while the queue takes beats until full.
// Input stall rises only when the queue is full; the bound is the single execute stage.
// Reset (synchronous, active high) zeroes divider, counter, modulo and control, empties the queue.
module divider_timer_with_modulo_reload_top
  import dtmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [15:0]           address,
  input  logic [BYTE_WIDTH-1:0] write_data,
  input  logic [CYC_WIDTH-1:0]  elapsed_cycles,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_WIDTH-1:0] read_data,
  output logic                  handled,
  output logic                  timer_interrupt
);

  cmd_t   dec_cmd;
  qhead_t q_head;
  logic   q_full;
  logic   q_pop;

  assign in_stall = q_full;

  // Decode
  dtmr_front u_front (
    .operation      (operation),
    .address        (address),
    .write_data     (write_data),
    .elapsed_cycles (elapsed_cycles),
    .cmd            (dec_cmd)
  );

  // Command queue
  dtmr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid),
    .push_cmd (dec_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // Execute
  dtmr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_data       (read_data),
    .handled         (handled),
    .timer_interrupt (timer_interrupt)
  );

endmodule
